// ===== rtl/core/stmg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmg_pkg
// Shared types, constants and helpers of the gap-limited run search block.
// ----------------------------------------------------------------------------
package stmg_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_TABLE_LEVELS = 10;
    localparam int ELEM_W           = 32;
    localparam int GAP_W            = 33;
    localparam int POS_W            = 11;
    localparam int CNT_W            = 17;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BL0_A,
        S_BL0_B,
        S_BL0_C,
        S_BLJ_A,
        S_BLJ_B,
        S_BLJ_C,
        S_Q1_CHK,
        S_Q1_B,
        S_Q1_C,
        S_Q2_CHK,
        S_RM_INIT,
        S_RM_RD,
        S_RM_ACC,
        S_RM_LRD,
        S_RM_FIN
    } t_state;

    typedef struct packed {
        logic start;
        logic op;
        logic last;
        logic out_free;
    } t_eng_cmd;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

    // Floor of log2 of a nonzero count.
    function automatic logic [4:0] f_flog2(input logic [CNT_W-1:0] v);
        logic [4:0] r;
        r = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (v[b]) begin
                r = 5'(b);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/stmg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmg_in_if / stmg_out_if
// Valid/ready channels for query and load items and for results.
// ----------------------------------------------------------------------------
interface stmg_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] element;
    logic               last;
    logic signed [31:0] target;
    logic signed [31:0] max_gap;
    modport source (output valid, operation, element, last, target, max_gap, input ready);
    modport sink (input valid, operation, element, last, target, max_gap, output ready);
endinterface

interface stmg_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] position;
    modport source (output valid, position, input ready);
    modport sink (input valid, position, output ready);
endinterface

// ===== rtl/core/stmg_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmg_engine
// Sequencer with value and gap memories: table build and both searches.
// ----------------------------------------------------------------------------
module stmg_engine #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int TABLE_LEVELS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  stmg_pkg::t_eng_cmd      i_cmd,
    input  logic signed [31:0]      i_element,
    input  logic signed [31:0]      i_target,
    input  logic signed [31:0]      i_max_gap,
    output stmg_pkg::t_eng_sts      o_sts,
    output logic [10:0]             o_position
);
    import stmg_pkg::*;

    localparam int XW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int LW = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
    localparam int GD = 2 ** (LW + XW);

    logic signed [ELEM_W-1:0] r_vmem [MAX_ELEMENTS];
    logic signed [GAP_W-1:0]  r_gmem [GD];
    logic signed [ELEM_W-1:0] r_vq;
    logic signed [GAP_W-1:0]  r_gq;

    t_state r_state, n_state;
    logic [CW-1:0]  r_count;
    logic           r_built;
    logic [XW-1:0]  r_x, r_a, r_b, r_k, r_m, r_i, r_lo, r_cnt, r_w;
    logic [LW-1:0]  r_j, r_p;
    logic           r_first;
    logic signed [ELEM_W-1:0] r_opv, r_t;
    logic signed [GAP_W-1:0]  r_opg, r_acc, r_d;

    // Combinational control values.
    logic [CW-1:0]  c_cnt0, c_cnt_new;
    logic           c_store;
    logic [XW-1:0]  v_raddr;
    logic [LW+XW-1:0] g_raddr, g_waddr;
    logic           g_we;
    logic signed [GAP_W-1:0] g_wdata;
    logic           c_l0_more, c_lj_more, c_next_lvl;
    logic [LW:0]    c_jn;
    logic [XW:0]    c_mid1, c_mid2;
    logic           c_q_le, c_q_gt;
    logic signed [GAP_W-1:0] c_max, c_mx_in;
    logic           c_rm_more;
    logic [4:0]     c_lg;
    logic [XW-1:0]  c_half;

    assign c_cnt0    = r_built ? '0 : r_count;
    assign c_store   = c_cnt0 < CW'(MAX_ELEMENTS);
    assign c_cnt_new = c_store ? c_cnt0 + 1'b1 : c_cnt0;
    assign c_l0_more = ((CW+1)'(r_x) + 2) < (CW+1)'(r_count);
    assign c_lj_more = ((CW+1)'(r_x) + 1 + ((CW+1)'(1) << r_j)) < (CW+1)'(r_count);
    assign c_jn      = (LW+1)'(r_j) + 1'b1;
    assign c_next_lvl = (c_jn < (LW+1)'(TABLE_LEVELS))
                        && (((r_count - 1'b1) >> c_jn) != '0);
    assign c_mid1    = (XW+1)'(r_a) + (XW+1)'(r_b);
    assign c_mid2    = (XW+1)'(r_a) + (XW+1)'(r_k);
    assign c_q_le    = r_opv <= r_t;
    assign c_q_gt    = r_vq > r_t;
    assign c_half    = XW'(1) << (r_j - 1'b1);
    // Shared max unit for the build and for range-maximum lookups.
    assign c_mx_in   = (r_state == S_BLJ_C) ? r_opg : r_acc;
    assign c_max     = (r_gq > c_mx_in) ? r_gq : c_mx_in;
    assign c_rm_more = (XW+1)'(r_cnt) > ((XW+1)'(r_w) << 1);
    assign c_lg      = f_flog2(CNT_W'(r_cnt));

    // Memory addressing.
    always_comb begin
        v_raddr = r_x;
        g_raddr = {r_p, r_lo};
        g_we    = 1'b0;
        g_waddr = {r_j, r_x};
        g_wdata = c_max;
        unique case (r_state)
            S_BL0_B: v_raddr = r_x + 1'b1;
            S_BL0_C: begin
                g_we    = 1'b1;
                g_wdata = GAP_W'(r_vq) - GAP_W'(r_opv);
            end
            S_BLJ_A: g_raddr = {r_j - 1'b1, r_x};
            S_BLJ_B: g_raddr = {r_j - 1'b1, r_x + c_half};
            S_BLJ_C: g_we = 1'b1;
            S_Q1_CHK: v_raddr = c_mid1[XW:1];
            S_Q1_B: v_raddr = r_m + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_cmd.op == OP_LOAD && c_store) begin
            r_vmem[c_cnt0[XW-1:0]] <= i_element;
        end
        r_vq <= r_vmem[v_raddr];
        if (g_we) begin
            r_gmem[g_waddr] <= g_wdata;
        end
        r_gq <= r_gmem[g_raddr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    if (i_cmd.op == OP_LOAD) begin
                        if (i_cmd.last && c_cnt_new >= CW'(2)) n_state = S_BL0_A;
                    end else if (r_built && r_count != '0) begin
                        n_state = S_Q1_CHK;
                    end
                end
            end
            S_BL0_A: n_state = S_BL0_B;
            S_BL0_B: n_state = S_BL0_C;
            S_BL0_C: n_state = c_l0_more ? S_BL0_A : (c_next_lvl ? S_BLJ_A : S_IDLE);
            S_BLJ_A: n_state = S_BLJ_B;
            S_BLJ_B: n_state = S_BLJ_C;
            S_BLJ_C: n_state = (c_lj_more || c_next_lvl) ? S_BLJ_A : S_IDLE;
            S_Q1_CHK: n_state = (r_a < r_b) ? S_Q1_B : S_Q2_CHK;
            S_Q1_B: n_state = S_Q1_C;
            S_Q1_C: n_state = (c_q_le && c_q_gt) ? S_Q2_CHK : S_Q1_CHK;
            S_Q2_CHK: begin
                if (r_a < r_k) n_state = S_RM_INIT;
                else if (i_cmd.out_free) n_state = S_IDLE;
            end
            S_RM_INIT: n_state = S_RM_RD;
            S_RM_RD: n_state = S_RM_ACC;
            S_RM_ACC: n_state = c_rm_more ? S_RM_RD : S_RM_LRD;
            S_RM_LRD: n_state = S_RM_FIN;
            S_RM_FIN: n_state = S_Q2_CHK;
            default: n_state = S_IDLE;
        endcase
    end

    // Status outputs.
    always_comb begin
        o_sts.idle = (r_state == S_IDLE);
        o_sts.done = (r_state == S_Q2_CHK) && !(r_a < r_k) && i_cmd.out_free;
        o_position = 11'((XW+1)'(r_a) + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_cmd.start && i_cmd.op == OP_LOAD) begin
                r_count <= c_cnt_new;
                r_built <= i_cmd.last;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x <= '0;
                r_j <= '0;
                r_a <= '0;
                r_b <= XW'(r_count - 1'b1);
                r_t <= i_target;
                r_d <= GAP_W'(i_max_gap);
            end
            S_BL0_B: r_opv <= r_vq;
            S_BL0_C: begin
                if (c_l0_more) begin
                    r_x <= r_x + 1'b1;
                end else begin
                    r_x <= '0;
                    r_j <= r_j + 1'b1;
                end
            end
            S_BLJ_B: r_opg <= r_gq;
            S_BLJ_C: begin
                if (c_lj_more) begin
                    r_x <= r_x + 1'b1;
                end else begin
                    r_x <= '0;
                    r_j <= r_j + 1'b1;
                end
            end
            S_Q1_CHK: begin
                r_m <= c_mid1[XW:1];
                if (!(r_a < r_b)) begin
                    r_k <= r_a;
                    r_a <= '0;
                end
            end
            S_Q1_B: r_opv <= r_vq;
            S_Q1_C: begin
                if (c_q_le && c_q_gt) begin
                    r_k <= r_m;
                    r_a <= '0;
                end else if (c_q_le) begin
                    r_a <= r_m + 1'b1;
                end else begin
                    r_b <= r_m;
                end
            end
            S_Q2_CHK: begin
                r_i   <= c_mid2[XW:1];
                r_lo  <= c_mid2[XW:1];
                r_cnt <= r_k - c_mid2[XW:1];
            end
            S_RM_INIT: begin
                if ({1'b0, c_lg} > 6'(TABLE_LEVELS - 1)) begin
                    r_p <= LW'(TABLE_LEVELS - 1);
                    r_w <= XW'(1) << (TABLE_LEVELS - 1);
                end else begin
                    r_p <= LW'(c_lg);
                    r_w <= XW'(1) << c_lg;
                end
                r_first <= 1'b1;
            end
            S_RM_ACC: begin
                r_acc   <= r_first ? r_gq : c_max;
                r_first <= 1'b0;
                if (c_rm_more) begin
                    r_lo  <= r_lo + r_w;
                    r_cnt <= r_cnt - r_w;
                end else begin
                    r_lo  <= r_lo + r_cnt - r_w;
                end
            end
            S_RM_FIN: begin
                if (c_max <= r_d) r_k <= r_i;
                else r_a <= r_i + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/sparse_table_max_gap_run_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_max_gap_run_search
// Loads an ascending array, builds a sparse table of adjacent gaps and
// answers run-start queries against it.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_in. An item with operation clear stores one
// element; the element marked last builds the gap table. A query item
// (operation set) returns one result on o_out, the one-based start of the
// longest run ending at the last element not above the target whose gaps
// all stay within max_gap. Queries before a built table give no result.
// A load stores its element; the last load then builds the table level by
// level. A query runs a binary search for the end index, then a binary
// search for the start; each step of the start search takes the gap maximum
// over its range from the top-level table windows. Each memory has a single
// read port. i_in.ready is high only while the sequencer is idle. The result
// sits in an output register, so the next item is taken while it waits; a
// query that finishes while the register is still full waits for the
// receiver. Reset empties the array and clears the table-built flag; memory
// contents are left as they are.
// ----------------------------------------------------------------------------
module sparse_table_max_gap_run_search #(
    parameter int MAX_ELEMENTS = stmg_pkg::DEF_MAX_ELEMENTS,
    parameter int TABLE_LEVELS = stmg_pkg::DEF_TABLE_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stmg_in_if.sink     i_in,
    stmg_out_if.source  o_out
);
    import stmg_pkg::*;

    t_eng_cmd    w_cmd;
    t_eng_sts    w_sts;
    logic [10:0] w_pos;
    logic        r_ovalid;
    logic [10:0] r_opos;

    assign i_in.ready     = w_sts.idle;
    assign w_cmd.start    = i_in.valid && w_sts.idle;
    assign w_cmd.op       = i_in.operation;
    assign w_cmd.last     = i_in.last;
    // The output register is free when empty or being emptied this cycle.
    assign w_cmd.out_free = !r_ovalid || o_out.ready;

    stmg_engine #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .TABLE_LEVELS(TABLE_LEVELS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_element  (i_in.element),
        .i_target   (i_in.target),
        .i_max_gap  (i_in.max_gap),
        .o_sts      (w_sts),
        .o_position (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_sts.done) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done) begin
            r_opos <= w_pos;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.position = r_opos;

endmodule

// ===== rtl/core/stmg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmg_checker
// Port-level checks of the run search block, bound to the top level.
// ----------------------------------------------------------------------------
module stmg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_operation,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [10:0] i_out_position
);
    import stmg_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_operation == OP_LOAD && !i_out_valid
        |=> !i_out_valid)
        else $error("load item produced a result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_position))
        else $error("stalled result changed");

endmodule

bind sparse_table_max_gap_run_search stmg_checker u_stmg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position)
);
